### src/mie_pkg.sv
// mips32 instruction execute: shared constants, opcode codes, fsm state and command types
// no dependencies; compiled first
package mie_pkg;

  localparam int unsigned DMEM_WORDS = 1024;
  localparam int unsigned DMEM_AW    = $clog2(DMEM_WORDS);

  localparam logic [31:0] PC_RESET        = 32'h0040_0000;
  localparam logic [31:0] TEXT_BASE_RESET = 32'h0040_0000;
  localparam logic [31:0] EXIT_CODE_A     = 32'd10;
  localparam logic [31:0] EXIT_CODE_B     = 32'd17;
  localparam logic [4:0]  REG_V0          = 5'd2;
  localparam logic [4:0]  REG_RA          = 5'd31;

  localparam logic [2:0] STS_OK     = 3'd0;
  localparam logic [2:0] STS_OVF    = 3'd1;
  localparam logic [2:0] STS_TRAP   = 3'd2;
  localparam logic [2:0] STS_EXIT   = 3'd3;
  localparam logic [2:0] STS_SYS    = 3'd4;
  localparam logic [2:0] STS_HALTED = 3'd5;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_XORI    = 6'h0e;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2b;
  localparam logic [5:0] OP_LL      = 6'h30;
  localparam logic [5:0] OP_SC      = 6'h38;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1a;
  localparam logic [5:0] FN_DIVU    = 6'h1b;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2a;
  localparam logic [5:0] FN_SLTU    = 6'h2b;
  localparam logic [5:0] FN_TGE     = 6'h30;
  localparam logic [5:0] FN_TGEU    = 6'h31;
  localparam logic [5:0] FN_TLT     = 6'h32;
  localparam logic [5:0] FN_TLTU    = 6'h33;
  localparam logic [5:0] FN_TEQ     = 6'h34;
  localparam logic [5:0] FN_TNE     = 6'h36;

  localparam logic [4:0] RI_BLTZ    = 5'h00;
  localparam logic [4:0] RI_BGEZ    = 5'h01;
  localparam logic [4:0] RI_TGEI    = 5'h08;
  localparam logic [4:0] RI_TGEIU   = 5'h09;
  localparam logic [4:0] RI_TLTI    = 5'h0a;
  localparam logic [4:0] RI_TLTIU   = 5'h0b;
  localparam logic [4:0] RI_TEQI    = 5'h0c;
  localparam logic [4:0] RI_TNEI    = 5'h0e;
  localparam logic [4:0] RI_BLTZAL  = 5'h10;
  localparam logic [4:0] RI_BGEZAL  = 5'h11;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic read;
    logic exec;
    logic div_step;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_div;
    logic div_last;
  } stat_t;

endpackage

### src/mie_ifs.sv
// mips32 instruction execute: valid/ready channel interfaces for instructions, results, config
// no dependencies
interface mie_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr;
  modport source (output valid, output instr, input ready);
  modport sink (input valid, input instr, output ready);
endinterface

interface mie_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic [2:0]  status;
  logic        wr_valid;
  logic [4:0]  wr_index;
  logic [31:0] wr_value;
  modport source (output valid, output next_pc, output status, output wr_valid,
                  output wr_index, output wr_value, input ready);
  modport sink (input valid, input next_pc, input status, input wr_valid,
                input wr_index, input wr_value, output ready);
endinterface

interface mie_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/mie_ctrl.sv
// mips32 instruction execute: controller state machine and result valid flag
// depends on mie_pkg
module mie_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  mie_pkg::stat_t stat,
  output mie_pkg::cmd_t  cmd
);
  import mie_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (stat.clear_last) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_READ;
      S_READ:  state_next = S_EXEC;
      S_EXEC:  state_next = stat.need_div ? S_DIV : S_DONE;
      S_DIV:   if (stat.div_last) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state)
      S_CLEAR: cmd.clear_step = 1'b1;
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_READ:  cmd.read = 1'b1;
      S_EXEC:  cmd.exec = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_DONE:  cmd.push = out_free;
      default: cmd = '0;
    endcase
    if (cmd.push) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

### src/mie_datapath.sv
// mips32 instruction execute: register file, hi/lo, pc, data memory, alu, divider, result regs
// depends on mie_pkg
module mie_datapath (
  input  logic           clk,
  input  logic           rst,
  input  mie_pkg::cmd_t  cmd,
  output mie_pkg::stat_t stat,
  input  logic [31:0]    instr,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_data,
  output logic [31:0]    next_pc,
  output logic [2:0]     status,
  output logic           wr_valid,
  output logic [4:0]     wr_index,
  output logic [31:0]    wr_value
);
  import mie_pkg::*;

  logic [31:0] gpr [32];
  logic [31:0] gpr_vld;
  logic [31:0] dmem [DMEM_WORDS];
  logic [DMEM_AW-1:0] clr_cnt;

  logic [31:0] text_base;
  logic [31:0] pc;
  logic [31:0] hi;
  logic [31:0] lo;
  logic        halted;

  logic [31:0] instr_q;
  logic [31:0] a_q;
  logic [31:0] b_q;
  logic [31:0] mem_q;

  logic [31:0] res_npc;
  logic [2:0]  res_status;
  logic        res_wr;
  logic [4:0]  res_dst;
  logic [31:0] res_val;

  logic [31:0] div_rem;
  logic [31:0] div_quo;
  logic [31:0] div_den;
  logic [4:0]  div_cnt;
  logic        div_na;
  logic        div_nb;

  // incoming decode for the register reads
  logic [4:0] rs_in;
  logic [4:0] rt_in;

  // decode of the held instruction
  logic [5:0]  op;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sa;
  logic [5:0]  fn;
  logic [15:0] imm;
  logic [31:0] zimm;
  logic [31:0] simm;
  logic [31:0] pc4;
  logic [31:0] btarget;
  logic [31:0] ea;
  logic [DMEM_AW-1:0] ea_idx;

  logic [31:0] sum_ab;
  logic [31:0] dif_ab;
  logic [31:0] sum_ai;
  logic [7:0]  ld_byte;
  logic [15:0] ld_half;
  logic        mul_signed;
  logic [65:0] mul_p;

  logic [31:0] x_npc;
  logic [2:0]  x_status;
  logic        x_wr;
  logic [4:0]  x_dst;
  logic [31:0] x_val;
  logic        x_trap;
  logic        x_hi_we;
  logic        x_lo_we;
  logic        x_mul;
  logic        x_div;
  logic        x_div_s;
  logic        x_mem_we;
  logic [31:0] x_mem_wd;
  logic        halt_now;
  logic        wr_ok;

  logic [32:0] rem_sh;
  logic        div_ge;
  logic [32:0] rem_sub;
  logic [31:0] rem_next;
  logic [31:0] quo_next;

  assign rs_in = instr[25:21];
  assign rt_in = (instr[31:26] == OP_SPECIAL && instr[5:0] == FN_SYSCALL) ? REG_V0
                                                                          : instr[20:16];

  assign op      = instr_q[31:26];
  assign rt      = instr_q[20:16];
  assign rd      = instr_q[15:11];
  assign sa      = instr_q[10:6];
  assign fn      = instr_q[5:0];
  assign imm     = instr_q[15:0];
  assign zimm    = {16'd0, imm};
  assign simm    = {{16{imm[15]}}, imm};
  assign pc4     = pc + 32'd4;
  assign btarget = pc4 + {simm[29:0], 2'b00};
  assign ea      = a_q + simm;
  assign ea_idx  = ea[DMEM_AW+1:2];

  assign sum_ab  = a_q + b_q;
  assign dif_ab  = a_q - b_q;
  assign sum_ai  = a_q + simm;
  assign ld_byte = 8'(mem_q >> {ea[1:0], 3'b000});
  assign ld_half = ea[1] ? mem_q[31:16] : mem_q[15:0];

  assign mul_signed = (fn == FN_MULT);
  assign mul_p = 66'($signed({mul_signed & a_q[31], a_q}) * $signed({mul_signed & b_q[31], b_q}));

  assign stat.clear_last = (clr_cnt == DMEM_AW'(DMEM_WORDS - 1));
  assign stat.need_div   = x_div;
  assign stat.div_last   = (div_cnt == 5'd31);

  always_comb begin
    x_npc    = pc4;
    x_status = STS_OK;
    x_wr     = 1'b0;
    x_dst    = 5'd0;
    x_val    = 32'd0;
    x_trap   = 1'b0;
    x_hi_we  = 1'b0;
    x_lo_we  = 1'b0;
    x_mul    = 1'b0;
    x_div    = 1'b0;
    x_div_s  = 1'b0;
    x_mem_we = 1'b0;
    x_mem_wd = mem_q;
    if (halted) begin
      x_npc    = pc;
      x_status = STS_HALTED;
    end else if (op == OP_SPECIAL) begin
      x_dst = rd;
      x_wr  = 1'b1;
      unique case (fn)
        FN_ADD: begin
          if (((a_q ^ sum_ab) & (b_q ^ sum_ab)) >> 31 != 32'd0) begin
            x_status = STS_OVF;
            x_wr     = 1'b0;
          end else begin
            x_val = sum_ab;
          end
        end
        FN_ADDU: x_val = sum_ab;
        FN_SUB: begin
          if (((a_q ^ b_q) & (a_q ^ dif_ab)) >> 31 != 32'd0) begin
            x_status = STS_OVF;
            x_wr     = 1'b0;
          end else begin
            x_val = dif_ab;
          end
        end
        FN_SUBU: x_val = dif_ab;
        FN_AND:  x_val = a_q & b_q;
        FN_OR:   x_val = a_q | b_q;
        FN_XOR:  x_val = a_q ^ b_q;
        FN_NOR:  x_val = ~(a_q | b_q);
        FN_SLT:  x_val = {31'd0, $signed(a_q) < $signed(b_q)};
        FN_SLTU: x_val = {31'd0, a_q < b_q};
        FN_SLL:  x_val = b_q << sa;
        FN_SRL:  x_val = b_q >> sa;
        FN_SRA:  x_val = $signed(b_q) >>> sa;
        FN_SLLV: x_val = b_q << a_q[4:0];
        FN_SRLV: x_val = b_q >> a_q[4:0];
        FN_SRAV: x_val = $signed(b_q) >>> a_q[4:0];
        FN_JR: begin
          x_npc = a_q;
          x_wr  = 1'b0;
        end
        FN_JALR: begin
          x_val = pc4;
          x_npc = a_q;
        end
        FN_MFHI: x_val = hi;
        FN_MFLO: x_val = lo;
        FN_MTHI: begin
          x_hi_we = 1'b1;
          x_wr    = 1'b0;
        end
        FN_MTLO: begin
          x_lo_we = 1'b1;
          x_wr    = 1'b0;
        end
        FN_MULT, FN_MULTU: begin
          x_mul = 1'b1;
          x_wr  = 1'b0;
        end
        FN_DIV, FN_DIVU: begin
          x_wr    = 1'b0;
          x_div   = (b_q != 32'd0);
          x_div_s = (fn == FN_DIV);
        end
        FN_TGE: begin
          x_wr   = 1'b0;
          x_trap = !($signed(a_q) < $signed(b_q));
        end
        FN_TGEU: begin
          x_wr   = 1'b0;
          x_trap = a_q >= b_q;
        end
        FN_TLT: begin
          x_wr   = 1'b0;
          x_trap = $signed(a_q) < $signed(b_q);
        end
        FN_TLTU: begin
          x_wr   = 1'b0;
          x_trap = a_q < b_q;
        end
        FN_TEQ: begin
          x_wr   = 1'b0;
          x_trap = a_q == b_q;
        end
        FN_TNE: begin
          x_wr   = 1'b0;
          x_trap = a_q != b_q;
        end
        FN_SYSCALL: begin
          x_wr     = 1'b0;
          x_status = (b_q == EXIT_CODE_A || b_q == EXIT_CODE_B) ? STS_EXIT : STS_SYS;
        end
        default: x_wr = 1'b0;
      endcase
    end else if (op == OP_J || op == OP_JAL) begin
      x_npc = text_base + {4'd0, instr_q[25:0], 2'b00};
      if (op == OP_JAL) begin
        x_wr  = 1'b1;
        x_dst = REG_RA;
        x_val = pc4;
      end
    end else if (op == OP_REGIMM) begin
      unique case (rt)
        RI_BLTZ: if (a_q[31]) x_npc = btarget;
        RI_BGEZ: if (!a_q[31]) x_npc = btarget;
        RI_BLTZAL: begin
          x_wr  = 1'b1;
          x_dst = REG_RA;
          x_val = pc4;
          if (a_q[31]) x_npc = btarget;
        end
        RI_BGEZAL: begin
          x_wr  = 1'b1;
          x_dst = REG_RA;
          x_val = pc4;
          if (!a_q[31]) x_npc = btarget;
        end
        RI_TGEI:  x_trap = !($signed(a_q) < $signed(simm));
        RI_TGEIU: x_trap = a_q >= simm;
        RI_TLTI:  x_trap = $signed(a_q) < $signed(simm);
        RI_TLTIU: x_trap = a_q < simm;
        RI_TEQI:  x_trap = a_q == simm;
        RI_TNEI:  x_trap = a_q != simm;
        default:  x_trap = 1'b0;
      endcase
    end else begin
      x_dst = rt;
      unique case (op)
        OP_BEQ:  if (a_q == b_q) x_npc = btarget;
        OP_BNE:  if (a_q != b_q) x_npc = btarget;
        OP_BLEZ: if (a_q == 32'd0 || a_q[31]) x_npc = btarget;
        OP_BGTZ: if (a_q != 32'd0 && !a_q[31]) x_npc = btarget;
        OP_ADDI: begin
          if (((a_q ^ sum_ai) & (simm ^ sum_ai)) >> 31 != 32'd0) begin
            x_status = STS_OVF;
          end else begin
            x_wr  = 1'b1;
            x_val = sum_ai;
          end
        end
        OP_ADDIU: begin
          x_wr  = 1'b1;
          x_val = sum_ai;
        end
        OP_SLTI: begin
          x_wr  = 1'b1;
          x_val = {31'd0, $signed(a_q) < $signed(simm)};
        end
        OP_SLTIU: begin
          x_wr  = 1'b1;
          x_val = {31'd0, a_q < simm};
        end
        OP_ANDI: begin
          x_wr  = 1'b1;
          x_val = a_q & zimm;
        end
        OP_ORI: begin
          x_wr  = 1'b1;
          x_val = a_q | zimm;
        end
        OP_XORI: begin
          x_wr  = 1'b1;
          x_val = a_q ^ zimm;
        end
        OP_LUI: begin
          x_wr  = 1'b1;
          x_val = {imm, 16'd0};
        end
        OP_LB: begin
          x_wr  = 1'b1;
          x_val = {{24{ld_byte[7]}}, ld_byte};
        end
        OP_LBU: begin
          x_wr  = 1'b1;
          x_val = {24'd0, ld_byte};
        end
        OP_LH: begin
          x_wr  = 1'b1;
          x_val = {{16{ld_half[15]}}, ld_half};
        end
        OP_LHU: begin
          x_wr  = 1'b1;
          x_val = {16'd0, ld_half};
        end
        OP_LW, OP_LL: begin
          x_wr  = 1'b1;
          x_val = mem_q;
        end
        OP_SB: begin
          x_mem_we = 1'b1;
          for (int i = 0; i < 4; i++) begin
            if (ea[1:0] == 2'(i)) x_mem_wd[i*8 +: 8] = b_q[7:0];
          end
        end
        OP_SH: begin
          x_mem_we = 1'b1;
          if (ea[1]) begin
            x_mem_wd[31:16] = b_q[15:0];
          end else begin
            x_mem_wd[15:0] = b_q[15:0];
          end
        end
        OP_SW, OP_SC: begin
          x_mem_we = 1'b1;
          x_mem_wd = b_q;
        end
        default: x_wr = 1'b0;
      endcase
    end
    if (x_trap) x_status = STS_TRAP;
  end

  assign halt_now = (x_status == STS_OVF) || (x_status == STS_TRAP) || (x_status == STS_EXIT);
  assign wr_ok    = x_wr && !halt_now && (x_dst != 5'd0);

  // restoring divider, one quotient bit a cycle
  assign rem_sh   = {div_rem, div_quo[31]};
  assign div_ge   = rem_sh >= {1'b0, div_den};
  assign rem_sub  = rem_sh - {1'b0, div_den};
  assign rem_next = div_ge ? rem_sub[31:0] : rem_sh[31:0];
  assign quo_next = {div_quo[30:0], div_ge};

  // control state with reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      text_base <= TEXT_BASE_RESET;
      pc        <= PC_RESET;
      hi        <= 32'd0;
      lo        <= 32'd0;
      halted    <= 1'b0;
      gpr_vld   <= 32'd0;
      clr_cnt   <= '0;
      div_cnt   <= 5'd0;
    end else begin
      if (cfg_we) text_base <= cfg_data;
      if (cmd.clear_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.exec) begin
        pc     <= halt_now ? pc : x_npc;
        halted <= halted | halt_now;
        if (wr_ok) gpr_vld[x_dst] <= 1'b1;
        if (x_hi_we) hi <= a_q;
        if (x_lo_we) lo <= a_q;
        if (x_mul) begin
          hi <= mul_p[63:32];
          lo <= mul_p[31:0];
        end
        div_cnt <= 5'd0;
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt + 5'd1;
        if (stat.div_last) begin
          lo <= (div_na ^ div_nb) ? 32'd0 - quo_next : quo_next;
          hi <= div_na ? 32'd0 - rem_next : rem_next;
        end
      end
    end
  end

  // register file: one write, two registered reads
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_ok) gpr[x_dst] <= x_val;
    if (cmd.accept) begin
      instr_q <= instr;
      a_q     <= gpr_vld[rs_in] ? gpr[rs_in] : 32'd0;
      b_q     <= gpr_vld[rt_in] ? gpr[rt_in] : 32'd0;
    end
  end

  // data memory
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      dmem[clr_cnt] <= 32'd0;
    end else if (cmd.exec && x_mem_we) begin
      dmem[ea_idx] <= x_mem_wd;
    end
    if (cmd.read) mem_q <= dmem[ea_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_npc    <= halt_now ? pc : x_npc;
      res_status <= x_status;
      res_wr     <= wr_ok;
      res_dst    <= wr_ok ? x_dst : 5'd0;
      res_val    <= wr_ok ? x_val : 32'd0;
      if (x_div) begin
        div_na  <= x_div_s & a_q[31];
        div_nb  <= x_div_s & b_q[31];
        div_rem <= 32'd0;
        div_quo <= (x_div_s & a_q[31]) ? 32'd0 - a_q : a_q;
        div_den <= (x_div_s & b_q[31]) ? 32'd0 - b_q : b_q;
      end
    end
    if (cmd.div_step) begin
      div_rem <= rem_next;
      div_quo <= quo_next;
    end
    if (cmd.push) begin
      next_pc  <= res_npc;
      status   <= res_status;
      wr_valid <= res_wr;
      wr_index <= res_dst;
      wr_value <= res_val;
    end
  end

endmodule

### src/mips32_instruction_execute_top.sv
// mips32 instruction execute: top level joining controller and datapath to the channels
// depends on mie_pkg, mie_ifs, mie_ctrl, mie_datapath
//
// in_chan takes one mips32 instruction word per request, fetched from the
// address reported in the previous result (0x00400000 after reset).
// out_chan gives one result per instruction: next_pc, status and the
// general register write (wr_valid, wr_index, wr_value).
// cfg_chan writes text_base; it is always ready. the user must write it only while
// idle; the block does not enforce this. after accept each instruction passes the
// READ, EXEC and DONE states; div and divu with a nonzero divisor add a DIV state
// for the bit-serial divider, which works through all 32 quotient bits.
// one instruction is in flight at a time: the next request is taken once the
// result sits in the output register.
// reset is synchronous; afterwards the data memory is cleared one word a
// cycle, all 1024 words, with in_chan not ready during that pass.
// when out_chan stalls the result holds in the output register; a following
// instruction is still accepted and executed, and waits for the output slot.
module mips32_instruction_execute_top (
  input  logic         clk,
  input  logic         rst,
  mie_instr_if.sink    in_chan,
  mie_result_if.source out_chan,
  mie_cfg_if.sink      cfg_chan
);
  import mie_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_chan.ready = 1'b1;

  mie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mie_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .instr    (in_chan.instr),
    .cfg_we   (cfg_chan.valid),
    .cfg_data (cfg_chan.data),
    .next_pc  (out_chan.next_pc),
    .status   (out_chan.status),
    .wr_valid (out_chan.wr_valid),
    .wr_index (out_chan.wr_index),
    .wr_value (out_chan.wr_value)
  );

endmodule
